// ===== rtl/mm_pkg.sv =====
// Shared types, constants and helper functions for the matrix multiply core.
// Used by mm_store, mm_mac, mm_seq and matrix_multiply_core; depends on nothing.
`default_nettype none

package mm_pkg;

  // Store geometry and element format.
  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROD_W  = 2 * ELEM_WIDTH;

  // Fixed field widths of the stream items.
  localparam int OP_W        = 2;
  localparam int FIELD_IDX_W = 3;
  localparam int VALUE_W     = 16;
  localparam int ACC_W       = 35;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // Configuration port.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
  localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 4'd8;

  // Operation codes carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A   = 2'd0,
    OP_LOAD_B   = 2'd1,
    OP_MULTIPLY = 2'd2
  } op_e;

  // Write request into the element stores.
  typedef struct packed {
    logic                         we_a;
    logic                         we_b;
    logic [ADDR_W-1:0]            addr;
    logic signed [ELEM_WIDTH-1:0] data;
  } mm_wr_t;

  // Control that travels alongside one pair of operands into the MAC.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm_mac_ctrl_t;

  // A dimension register of zero acts as one, a value above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  // Row-major address of an element inside a store.
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM)) + ADDR_W'(col);
  endfunction

  // Fit the incoming Q8.8 value to the element width, keeping the sign.
  function automatic logic signed [ELEM_WIDTH-1:0] to_elem(
      input logic signed [VALUE_W-1:0] v);
    return ELEM_WIDTH'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mm_store.sv =====
// Element stores for matrices A and B: one write port and one registered read
// port each. Depends on mm_pkg.
`default_nettype none

module mm_store (
  input  wire logic                                      clk_i,
  input  wire mm_pkg::mm_wr_t                            wr_i,
  input  wire logic [mm_pkg::ADDR_W-1:0]                 rd_addr_a_i,
  input  wire logic [mm_pkg::ADDR_W-1:0]                 rd_addr_b_i,
  output logic signed [mm_pkg::ELEM_WIDTH-1:0]           rd_data_a_o,
  output logic signed [mm_pkg::ELEM_WIDTH-1:0]           rd_data_b_o
);

  logic signed [mm_pkg::ELEM_WIDTH-1:0] mem_a [mm_pkg::DEPTH];
  logic signed [mm_pkg::ELEM_WIDTH-1:0] mem_b [mm_pkg::DEPTH];
  logic signed [mm_pkg::ELEM_WIDTH-1:0] rd_a_q;
  logic signed [mm_pkg::ELEM_WIDTH-1:0] rd_b_q;

  // Store A: write, then registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.we_a) begin
      mem_a[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem_a[rd_addr_a_i];
  end

  // Store B: write, then registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.we_b) begin
      mem_b[wr_i.addr] <= wr_i.data;
    end
    rd_b_q <= mem_b[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

`default_nettype wire

// ===== rtl/mm_mac.sv =====
// Two-stage multiply-accumulate unit: a registered product, then a registered
// running sum that restarts on the first pair of each element. Depends on mm_pkg.
`default_nettype none

module mm_mac (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire mm_pkg::mm_mac_ctrl_t                  ctrl_i,
  input  wire logic signed [mm_pkg::ELEM_WIDTH-1:0]  a_i,
  input  wire logic signed [mm_pkg::ELEM_WIDTH-1:0]  b_i,
  output logic                                       done_o,
  output logic signed [mm_pkg::ACC_W-1:0]            acc_o
);

  logic signed [mm_pkg::PROD_W-1:0] prod_q;
  logic signed [mm_pkg::ACC_W-1:0]  acc_q;
  mm_pkg::mm_mac_ctrl_t             ctrl_q;
  logic                             done_q;

  // Control pipeline follows the operands through both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctrl_q <= ctrl_i;
      done_q <= ctrl_q.valid && ctrl_q.last;
    end
  end

  // Product stage, then the accumulate stage.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctrl_q.valid) begin
      if (ctrl_q.first) begin
        acc_q <= mm_pkg::ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + mm_pkg::ACC_W'(prod_q);
      end
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

  // A finished sum follows the last pair of an element through the control and done registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.valid && ctrl_i.last) |-> ##2 done_q)
    else $error("mm_mac: done did not follow the last operand pair");

  // No sum completes without a preceding last pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(ctrl_i.valid && ctrl_i.last, 2))
    else $error("mm_mac: done without a last operand pair");

endmodule

`default_nettype wire

// ===== rtl/mm_seq.sv =====
// Sequencer: takes load and multiply items, walks the product indices, issues
// store reads to the MAC and holds the output register. Depends on mm_pkg.
`default_nettype none

module mm_seq (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration writes
  input  wire logic                                  cfg_we_i,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [mm_pkg::CFG_W-1:0]              cfg_data_i,
  // Input items
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [mm_pkg::OP_W-1:0]               in_op_i,
  input  wire logic [mm_pkg::FIELD_IDX_W-1:0]        in_row_i,
  input  wire logic [mm_pkg::FIELD_IDX_W-1:0]        in_col_i,
  input  wire logic signed [mm_pkg::VALUE_W-1:0]     in_value_i,
  // Store access
  output mm_pkg::mm_wr_t                             wr_o,
  output logic [mm_pkg::ADDR_W-1:0]                  rd_addr_a_o,
  output logic [mm_pkg::ADDR_W-1:0]                  rd_addr_b_o,
  // MAC
  output mm_pkg::mm_mac_ctrl_t                       mac_ctrl_o,
  input  wire logic                                  mac_done_i,
  input  wire logic signed [mm_pkg::ACC_W-1:0]       mac_acc_i,
  // Result items
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [mm_pkg::FIELD_IDX_W-1:0]             out_row_o,
  output logic [mm_pkg::FIELD_IDX_W-1:0]             out_col_o,
  output logic signed [mm_pkg::ACC_W-1:0]            out_value_o,
  output logic                                       out_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PUSH
  } state_e;

  state_e                            state_q;
  logic [mm_pkg::CFG_W-1:0]          rows_a_q, inner_dim_q, cols_b_q;
  logic [mm_pkg::DIM_W-1:0]          nr_q, nk_q, nc_q;
  logic [mm_pkg::IDX_W-1:0]          i_q, j_q, k_q;
  mm_pkg::mm_mac_ctrl_t              rd_ctrl_q;
  logic                              out_valid_q;
  logic [mm_pkg::FIELD_IDX_W-1:0]    out_row_q, out_col_q;
  logic signed [mm_pkg::ACC_W-1:0]   out_value_q;
  logic                              out_last_q;

  logic in_xfer;
  logic in_in_range;
  logic k_last, j_last, i_last;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_in_range =
    ((mm_pkg::FIELD_IDX_W + 1)'(in_row_i) < (mm_pkg::FIELD_IDX_W + 1)'(mm_pkg::MAX_DIM)) &&
    ((mm_pkg::FIELD_IDX_W + 1)'(in_col_i) < (mm_pkg::FIELD_IDX_W + 1)'(mm_pkg::MAX_DIM));

  assign k_last   = (mm_pkg::DIM_W'(k_q) == nk_q - mm_pkg::DIM_W'(1));
  assign j_last   = (mm_pkg::DIM_W'(j_q) == nc_q - mm_pkg::DIM_W'(1));
  assign i_last   = (mm_pkg::DIM_W'(i_q) == nr_q - mm_pkg::DIM_W'(1));
  assign out_free = !out_valid_q || out_ready_i;

  // Element writes go straight to the stores during a load transfer.
  always_comb begin
    wr_o      = '0;
    wr_o.addr = mm_pkg::elem_addr(in_row_i[mm_pkg::IDX_W-1:0],
                                  in_col_i[mm_pkg::IDX_W-1:0]);
    wr_o.data = mm_pkg::to_elem(in_value_i);
    if (in_xfer && in_in_range) begin
      case (mm_pkg::op_e'(in_op_i))
        mm_pkg::OP_LOAD_A: wr_o.we_a = 1'b1;
        mm_pkg::OP_LOAD_B: wr_o.we_b = 1'b1;
        default:           wr_o      = wr_o;
      endcase
    end
  end

  // Operand addresses: A[i][k] and B[k][j].
  assign rd_addr_a_o = mm_pkg::elem_addr(i_q, k_q);
  assign rd_addr_b_o = mm_pkg::elem_addr(k_q, j_q);

  // State, index counters, dimension registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_a_q    <= mm_pkg::CFG_DIM_RESET;
      inner_dim_q <= mm_pkg::CFG_DIM_RESET;
      cols_b_q    <= mm_pkg::CFG_DIM_RESET;
      nr_q        <= '0;
      nk_q        <= '0;
      nc_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      rd_ctrl_q   <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Configuration registers.
      if (cfg_we_i) begin
        case (cfg_index_i)
          mm_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
          mm_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
          mm_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data_i;
          default:               rows_a_q    <= rows_a_q;
        endcase
      end

      // The output register empties on a transfer; the push state refills it itself.
      if (out_valid_q && out_ready_i && (state_q != ST_PUSH)) begin
        out_valid_q <= 1'b0;
      end

      if (state_q != ST_RUN) begin
        rd_ctrl_q <= '0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (mm_pkg::op_e'(in_op_i) == mm_pkg::OP_MULTIPLY)) begin
            nr_q    <= mm_pkg::clamp_dim(rows_a_q);
            nk_q    <= mm_pkg::clamp_dim(inner_dim_q);
            nc_q    <= mm_pkg::clamp_dim(cols_b_q);
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          // One operand pair per cycle; read data lines up with rd_ctrl_q.
          // Fields from the top: valid, first, last.
          rd_ctrl_q <= {1'b1, (k_q == '0), k_last};
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + mm_pkg::IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          if (mac_done_i) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= mm_pkg::FIELD_IDX_W'(i_q);
            out_col_q   <= mm_pkg::FIELD_IDX_W'(j_q);
            out_value_q <= mac_acc_i;
            out_last_q  <= i_last && j_last;
            if (j_last) begin
              j_q <= '0;
              if (i_last) begin
                state_q <= ST_IDLE;
              end else begin
                i_q     <= i_q + mm_pkg::IDX_W'(1);
                state_q <= ST_RUN;
              end
            end else begin
              j_q     <= j_q + mm_pkg::IDX_W'(1);
              state_q <= ST_RUN;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign mac_ctrl_o  = rd_ctrl_q;
  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // The MAC only finishes an element while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done_i |-> (state_q == ST_DRAIN))
    else $error("mm_seq: MAC result arrived outside the drain state");

  // Stores are written only while no multiply is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.we_a || wr_o.we_b) |-> (state_q == ST_IDLE))
    else $error("mm_seq: store write during a multiply");

  // The inner index stays inside the inner dimension while reading operands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (mm_pkg::DIM_W'(k_q) < nk_q))
    else $error("mm_seq: inner index out of range");

  // A result handed to a free output register is presented next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PUSH) && out_free) |=> out_valid_q)
    else $error("mm_seq: result lost when loading the output register");

  // A last result returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PUSH) && out_free && i_last && j_last) |=> (state_q == ST_IDLE))
    else $error("mm_seq: sequencer did not finish after the last element");

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply_core.sv =====
// Top level of the fixed-point matrix multiply core: stream ports, the
// configuration port, and the sequencer, stores and MAC. Depends on mm_pkg.
`default_nettype none

// A load transfer (tuser 0 for A, 1 for B) writes one Q8.8 element; row or
// column indices beyond the store are dropped. A multiply transfer (tuser 2)
// emits rows_a x cols_b Q19.16 results in row-major order with tlast on the
// final one. Each result reads its operand pairs from the two element
// memories into the single multiply-accumulate unit, then passes through the
// memory read, product and accumulate stages, then the load into the output
// register. Back-pressure on the output stretches a multiply. Dimension
// registers of zero act as one, values above eight as eight. Input is not
// taken while a multiply runs; the final result may still wait in the output
// register while the next item is taken. Elements read by a multiply must have
// been loaded since reset.

module matrix_multiply_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // Configuration port
  input  wire logic                                  cfg_we_i,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [mm_pkg::CFG_W-1:0]              cfg_data_i,
  // Input stream
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // tdata: row_index [2:0], col_index [5:3], value [21:6], zero [23:22]
  input  wire logic [mm_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  // tuser: operation [1:0]
  input  wire logic [mm_pkg::OP_W-1:0]               s_axis_tuser,
  // Output stream
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // tdata: result_row [2:0], result_col [5:3], product_value [40:6], zero [47:41]
  output logic [mm_pkg::OUT_TDATA_W-1:0]             m_axis_tdata,
  output logic                                       m_axis_tlast
);

  localparam int ColLsb   = mm_pkg::FIELD_IDX_W;
  localparam int ValueLsb = 2 * mm_pkg::FIELD_IDX_W;
  localparam int PadW     = mm_pkg::OUT_TDATA_W - ValueLsb - mm_pkg::ACC_W;

  mm_pkg::mm_wr_t                         wr;
  logic [mm_pkg::ADDR_W-1:0]              rd_addr_a, rd_addr_b;
  logic signed [mm_pkg::ELEM_WIDTH-1:0]   rd_data_a, rd_data_b;
  mm_pkg::mm_mac_ctrl_t                   mac_ctrl;
  logic                                   mac_done;
  logic signed [mm_pkg::ACC_W-1:0]        mac_acc;
  logic [mm_pkg::FIELD_IDX_W-1:0]         out_row, out_col;
  logic signed [mm_pkg::ACC_W-1:0]        out_value;

  mm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_row_i    (s_axis_tdata[ColLsb-1:0]),
    .in_col_i    (s_axis_tdata[ValueLsb-1:ColLsb]),
    .in_value_i  (s_axis_tdata[ValueLsb+mm_pkg::VALUE_W-1:ValueLsb]),
    .wr_o        (wr),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .mac_ctrl_o  (mac_ctrl),
    .mac_done_i  (mac_done),
    .mac_acc_i   (mac_acc),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  mm_store u_store (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  mm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (rd_data_a),
    .b_i    (rd_data_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {{PadW{1'b0}}, out_value, out_col, out_row};

endmodule

`default_nettype wire
